>>> hdl/irdq_pkg.sv
package irdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int OPCODE_W      = 2;
    localparam int STATUS_W      = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT    = 2'd0,
        OP_DEL_FRONT = 2'd1,
        OP_DEL_REAR  = 2'd2,
        OP_DUMP      = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        CMD_STATUS = 1'b0,
        CMD_DUMP   = 1'b1
    } cmd_kind_t;

    // Work handed from the front part to the back part
    typedef struct packed {
        cmd_kind_t kind;
        status_t   status;
    } cmd_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_DUMP = 1'b1
    } back_state_t;

endpackage

>>> hdl/irdq_ram.sv
module irdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/irdq_fifo.sv
module irdq_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    // Two-entry command queue
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/irdq_front.sv
module irdq_front #(
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [irdq_pkg::OPCODE_W-1:0]       s_tuser,
    input  logic [irdq_pkg::VALUE_W-1:0]        s_tdata,
    output logic                                push_valid,
    input  logic                                push_ready,
    output irdq_pkg::cmd_t                      push_cmd,
    output logic [$clog2(DEPTH)-1:0]            push_start,
    output logic [$clog2(DEPTH+1)-1:0]          push_count,
    output logic                                ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]            ram_wr_addr,
    output logic [irdq_pkg::VALUE_W-1:0]        ram_wr_data,
    input  logic                                dump_done
);

    import irdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dump_busy_reg, dump_busy_next;
    logic             accept;
    logic [SUM_W-1:0] rear_sum, inc_sum;
    logic [IDX_W-1:0] rear_idx, front_inc;
    op_t              op;

    assign s_tready = push_ready && !dump_busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);

    // Ring position of the first free slot and of the entry after the front
    assign rear_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign rear_idx  = (rear_sum >= SUM_W'(DEPTH)) ? IDX_W'(rear_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(rear_sum);
    assign inc_sum   = SUM_W'(front_reg) + SUM_W'(1);
    assign front_inc = (inc_sum >= SUM_W'(DEPTH)) ? IDX_W'(inc_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(inc_sum);

    assign ram_wr_addr = rear_idx;
    assign ram_wr_data = s_tdata;
    assign push_start  = front_reg;
    assign push_count  = count_reg;
    assign push_valid  = accept;

    always_comb begin
        front_next      = front_reg;
        count_next      = count_reg;
        dump_busy_next  = dump_busy_reg && !dump_done;
        ram_wr_en       = 1'b0;
        push_cmd.kind   = CMD_STATUS;
        push_cmd.status = ST_OK;
        if (accept) begin
            case (op)
                OP_INSERT: begin
                    if (count_reg == CNT_W'(DEPTH)) begin
                        push_cmd.status = ST_FULL;
                    end else begin
                        ram_wr_en  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_DEL_FRONT: begin
                    if (count_reg == '0) begin
                        push_cmd.status = ST_EMPTY;
                    end else begin
                        front_next = front_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_DEL_REAR: begin
                    if (count_reg == '0) begin
                        push_cmd.status = ST_EMPTY;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_DUMP: begin
                    if (count_reg == '0) begin
                        push_cmd.status = ST_EMPTY;
                    end else begin
                        push_cmd.kind  = CMD_DUMP;
                        dump_busy_next = 1'b1;
                    end
                end
                default: begin
                    push_cmd.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            dump_busy_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            dump_busy_reg <= dump_busy_next;
        end
    end

endmodule

>>> hdl/irdq_back.sv
module irdq_back #(
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  irdq_pkg::cmd_t                      pop_cmd,
    input  logic [$clog2(DEPTH)-1:0]            pop_start,
    input  logic [$clog2(DEPTH+1)-1:0]          pop_count,
    output logic                                ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]            ram_rd_addr,
    input  logic [irdq_pkg::VALUE_W-1:0]        ram_rd_data,
    output logic                                dump_done,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [irdq_pkg::STATUS_W-1:0]       m_tuser,
    output logic [irdq_pkg::VALUE_W-1:0]        m_tdata,
    output logic                                m_tlast
);

    import irdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    back_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     remain_reg, remain_next;
    logic                 rd_pending_reg, rd_pending_next;
    logic                 rd_last_reg, rd_last_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [VALUE_W-1:0]   m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;
    logic                 out_free, load_rd, issue, do_pop;
    logic [IDX_W:0]       ptr_sum;

    assign out_free  = !m_valid_reg || m_tready;
    assign load_rd   = rd_pending_reg && out_free;
    assign issue     = (state_reg == BK_DUMP) && (remain_reg != '0)
                       && (!rd_pending_reg || load_rd);
    assign pop_ready = (state_reg == BK_IDLE) && ((pop_cmd.kind == CMD_DUMP) || out_free);
    assign do_pop    = pop_valid && pop_ready;
    assign ptr_sum   = (IDX_W+1)'(rd_ptr_reg) + (IDX_W+1)'(1);

    assign ram_rd_en   = issue;
    assign ram_rd_addr = rd_ptr_reg;
    assign dump_done   = load_rd && rd_last_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        state_next      = state_reg;
        rd_ptr_next     = rd_ptr_reg;
        remain_next     = remain_reg;
        rd_pending_next = rd_pending_reg;
        rd_last_next    = rd_last_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        case (state_reg)
            BK_IDLE: begin
                if (do_pop) begin
                    if (pop_cmd.kind == CMD_DUMP) begin
                        state_next  = BK_DUMP;
                        rd_ptr_next = pop_start;
                        remain_next = pop_count;
                    end
                end
            end
            BK_DUMP: begin
                if (issue) begin
                    rd_ptr_next     = (ptr_sum == (IDX_W+1)'(DEPTH)) ? '0 : IDX_W'(ptr_sum);
                    remain_next     = remain_reg - CNT_W'(1);
                    rd_pending_next = 1'b1;
                    rd_last_next    = (remain_reg == CNT_W'(1));
                end else if (load_rd) begin
                    rd_pending_next = 1'b0;
                end
                if (dump_done) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        // Output register: a status word or a read-out entry
        if (do_pop && (pop_cmd.kind == CMD_STATUS)) begin
            m_valid_next  = 1'b1;
            m_status_next = pop_cmd.status;
            m_data_next   = '0;
            m_last_next   = 1'b1;
        end else if (load_rd) begin
            m_valid_next  = 1'b1;
            m_status_next = ST_OK;
            m_data_next   = ram_rd_data;
            m_last_next   = rd_last_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            remain_reg     <= '0;
            rd_pending_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            remain_reg     <= remain_next;
            rd_pending_reg <= rd_pending_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        rd_last_reg  <= rd_last_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

endmodule

>>> hdl/input_restricted_deque.sv
// Input-restricted deque of DEPTH signed 32-bit entries kept in a ring RAM.
// Each item carries an opcode on s_tuser and a value on s_tdata: insert at
// rear, delete front, delete rear, or dump. Insert and the two deletes give
// one result each with a status on m_tuser (ok, empty, full) and zero data;
// an insert into a full deque is dropped. A dump streams every entry front to
// rear with status ok and m_tlast on the rear entry; a dump of an empty deque
// gives one empty status. All results carry m_tlast on the final result of
// their item. Rate: insert and delete items go through at one per cycle
// while no dump is in progress and the output is not stalled, set by the
// front part's single pointer update and the one-word status path of the
// back part. A dump picks up the command, then reads one entry per cycle
// while the output is not stalled, through the RAM's read register; the
// front part takes no new item from the dump's acceptance until its last
// entry is read, since a later insert could overwrite a slot being read out.
module input_restricted_deque #(
    parameter int DEPTH = irdq_pkg::DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [irdq_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] item_value
    input  logic [irdq_pkg::OPCODE_W-1:0]   s_tuser,   // [1:0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [irdq_pkg::VALUE_W-1:0]    m_tdata,   // [31:0] entry_value
    output logic [irdq_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    output logic                            m_tlast    // last_of_run
);

    import irdq_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMD_W  = $bits(cmd_t) + IDX_W + CNT_W;

    // Front to queue
    logic             push_valid, push_ready;
    cmd_t             push_cmd;
    logic [IDX_W-1:0] push_start;
    logic [CNT_W-1:0] push_count;

    // Queue to back
    logic             pop_valid, pop_ready;
    logic [CMD_W-1:0] pop_word;
    cmd_t             pop_cmd;
    logic [IDX_W-1:0] pop_start;
    logic [CNT_W-1:0] pop_count;

    // Entry store ports
    logic               ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [VALUE_W-1:0] ram_wr_data, ram_rd_data;

    logic dump_done;

    irdq_front #(.DEPTH(DEPTH)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd),
        .push_start  (push_start),
        .push_count  (push_count),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .dump_done   (dump_done)
    );

    irdq_fifo #(.WIDTH(CMD_W)) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_cmd, push_start, push_count}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_word)
    );

    // Unpack the queued command
    assign pop_cmd   = cmd_t'(pop_word[CMD_W-1 -: $bits(cmd_t)]);
    assign pop_start = pop_word[CNT_W +: IDX_W];
    assign pop_count = pop_word[CNT_W-1:0];

    irdq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    irdq_back #(.DEPTH(DEPTH)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_cmd     (pop_cmd),
        .pop_start   (pop_start),
        .pop_count   (pop_count),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .dump_done   (dump_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

>>> dv/tb_input_restricted_deque.sv
module tb_input_restricted_deque;

    import irdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 3 * DEPTH + 20;
    localparam int STALL_LEN   = 120;
    localparam int N_RANDOM    = 134;

    typedef struct {
        op_t         op;
        logic [31:0] value;
    } deque_op_t;

    typedef struct {
        status_t     status;
        logic [31:0] value;
        logic        last;
    } deque_result_t;

    logic aclk;
    logic aresetn = 1'b0;

    // Block inputs start at known values before the first edge
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata  = '0;   // [31:0] item_value
    logic [OPCODE_W-1:0]   s_tuser  = '0;   // [1:0] opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [VALUE_W-1:0]    m_tdata;         // [31:0] entry_value
    logic [STATUS_W-1:0]   m_tuser;         // [1:0] status
    logic                  m_tlast;

    input_restricted_deque #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Operations still to be sent, and results owed by the block, oldest first
    deque_op_t     queued_ops[$];
    deque_result_t owed_results[$];

    // Deque model: ring store, front position, fill level
    logic [31:0] ring_store [DEPTH];
    int unsigned ring_front = 0;
    int unsigned ring_fill  = 0;

    int total_ops      = 0;
    int accepted_ops   = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int results_seen   = 0;
    int full_hits      = 0;
    int empty_hits     = 0;
    int dumped_entries = 0;
    int op_hits [4]    = '{0, 0, 0, 0};

    // Receiver hold-off state, owned by the monitor
    int stall_left = 0;
    bit stall_done = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Model
    // ---------------------------------------------------------------------

    task automatic owe_status(input status_t st);
        deque_result_t r;
        r.status = st;
        r.value  = '0;
        r.last   = 1'b1;
        owed_results.push_back(r);
        if (st == ST_FULL) full_hits++;
        if (st == ST_EMPTY) empty_hits++;
    endtask

    // Apply one accepted operation to the model and queue the results it owes
    task automatic deque_apply(input op_t op, input logic [31:0] value);
        deque_result_t r;
        int unsigned   i;
        op_hits[op]++;
        case (op)
            OP_INSERT: begin
                if (ring_fill == DEPTH) begin
                    owe_status(ST_FULL);
                end else begin
                    ring_store[(ring_front + ring_fill) % DEPTH] = value;
                    ring_fill++;
                    owe_status(ST_OK);
                end
            end
            OP_DEL_FRONT: begin
                if (ring_fill == 0) begin
                    owe_status(ST_EMPTY);
                end else begin
                    // front advances even when this empties the deque
                    ring_front = (ring_front + 1) % DEPTH;
                    ring_fill--;
                    owe_status(ST_OK);
                end
            end
            OP_DEL_REAR: begin
                if (ring_fill == 0) begin
                    owe_status(ST_EMPTY);
                end else begin
                    ring_fill--;
                    owe_status(ST_OK);
                end
            end
            default: begin
                if (ring_fill == 0) begin
                    owe_status(ST_EMPTY);
                end else begin
                    for (i = 0; i < ring_fill; i++) begin
                        r.status = ST_OK;
                        r.value  = ring_store[(ring_front + i) % DEPTH];
                        r.last   = (i + 1 == ring_fill);
                        owed_results.push_back(r);
                    end
                    dumped_entries += ring_fill;
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    task automatic queue_op(input op_t op, input logic [31:0] value);
        deque_op_t d;
        d.op    = op;
        d.value = value;
        queued_ops.push_back(d);
    endtask

    // Mostly full-range random values, with the signed extremes mixed in
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Bias 0 fills, 1 drains, 2 mixes; dumps are drawn at the same share under every bias
    function automatic op_t pick_op(input int bias);
        int roll;
        roll = $urandom_range(99);
        if (roll < 12) return OP_DUMP;
        case (bias)
            0:       return (roll < 82) ? OP_INSERT
                          : ((roll < 91) ? OP_DEL_FRONT : OP_DEL_REAR);
            1:       return (roll < 30) ? OP_INSERT
                          : ((roll < 65) ? OP_DEL_FRONT : OP_DEL_REAR);
            default: return (roll < 50) ? OP_INSERT
                          : ((roll < 75) ? OP_DEL_FRONT : OP_DEL_REAR);
        endcase
    endfunction

    task automatic build_stimulus();
        int n;
        int bias;
        int burst;
        // Empty deque: the dump and both deletes report empty
        queue_op(OP_DUMP, 32'h1234_5678);
        queue_op(OP_DEL_FRONT, 32'hFFFF_FFFF);
        queue_op(OP_DEL_REAR, 32'h0);
        // Remove the only entry from the rear, then from the front
        queue_op(OP_INSERT, 32'h7FFF_FFFF);
        queue_op(OP_DEL_REAR, 32'h0);
        queue_op(OP_INSERT, 32'h8000_0000);
        queue_op(OP_DEL_FRONT, 32'h0);
        queue_op(OP_DUMP, 32'h0);
        // Fill to the brim from a shifted front, so the ring wraps
        queue_op(OP_INSERT, 32'hFFFF_FFFF);
        queue_op(OP_INSERT, 32'h0000_0000);
        for (n = 2; n < DEPTH; n++) queue_op(OP_INSERT, pick_value());
        queue_op(OP_INSERT, 32'hDEAD_BEEF);     // dropped, deque full
        queue_op(OP_DUMP, 32'h0);

        // Random bursts that swing the fill level between empty and full
        n = 0;
        while (n < N_RANDOM) begin
            bias  = $urandom_range(2);
            burst = $urandom_range(8, 28);
            for (int k = 0; k < burst && n < N_RANDOM; k++) begin
                queue_op(pick_op(bias), pick_value());
                n++;
            end
        end
    endtask

    // Sender and receiver idle rates follow the share of operations accepted
    function automatic int sender_idle_pct();
        if (accepted_ops < total_ops / 3) return 26;
        if (accepted_ops < 2 * total_ops / 3) return 87;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accepted_ops < total_ops / 3) return 87;
        if (accepted_ops < 2 * total_ops / 3) return 26;
        return 0;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: update the model on acceptance, then offer the next item
    // ---------------------------------------------------------------------

    always @(posedge aclk) begin
        deque_op_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                deque_apply(op_t'(s_tuser), s_tdata);
                accepted_ops <= accepted_ops + 1;
            end
            // Load a new item only when the current one is gone or absent
            if (!s_tvalid || s_tready) begin
                if (queued_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    nxt = queued_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= nxt.value;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest owed one
    // ---------------------------------------------------------------------

    always @(posedge aclk) begin
        deque_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    $error("result item with none owed: status %0d value %0d last %0b",
                           m_tuser, $signed(m_tdata), m_tlast);
                    error_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata !== want.value) begin
                        $error("entry_value mismatch: expected %0d, got %0d",
                               $signed(want.value), $signed(m_tdata));
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run mismatch: expected %0b, got %0b",
                               want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            // Once, hold off for a long stretch while the sender keeps
            // offering, so the block backs up and drops s_tready
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!stall_done && accepted_ops >= 2 * total_ops / 3 + 5) begin
                stall_done = 1'b1;
                stall_left = STALL_LEN;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------------

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles: %0d of %0d items accepted, %0d results owed",
                     cycle_count, accepted_ops, total_ops, owed_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence: reset, stimulus, drain, verdict
    // ---------------------------------------------------------------------

    initial begin
        build_stimulus();
        total_ops = queued_ops.size();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_ops < total_ops) @(posedge aclk);
        while (owed_results.size() != 0) @(posedge aclk);
        // Let any stray result surface before the verdict
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("ran %0d items: %0d inserts, %0d front deletes, %0d rear deletes, %0d dumps",
                 total_ops, op_hits[OP_INSERT], op_hits[OP_DEL_FRONT],
                 op_hits[OP_DEL_REAR], op_hits[OP_DUMP]);
        $display("checked %0d results: %0d dumped entries, %0d full drops, %0d empty reports",
                 results_seen, dumped_entries, full_hits, empty_hits);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
